/* design/stc_pkg.sv */
// Shared types, token codes and character classification functions for the tokenizer.
`default_nettype none
package stc_pkg;

    localparam int unsigned POS_W   = 16;
    localparam int unsigned VALUE_W = 31;
    localparam int unsigned KIND_W  = 6;
    localparam int unsigned MAX_KW  = 8;
    localparam int unsigned WIN_W   = 8 * MAX_KW;
    localparam int unsigned WLEN_W  = 4;

    localparam logic [POS_W-1:0]   POS_MAX = {POS_W{1'b1}};
    localparam logic [VALUE_W-1:0] NUM_MAX = {VALUE_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_EOF    = 6'd0;
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 6'd11;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 6'd34;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 6'd35;
    localparam logic [KIND_W-1:0] KIND_BOOL   = 6'd36;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [8:0] {
        M_IDLE   = 9'b000000001,
        M_OPER   = 9'b000000010,
        M_ZERO   = 9'b000000100,
        M_DEC    = 9'b000001000,
        M_PREFIX = 9'b000010000,
        M_WORD   = 9'b000100000,
        M_LINE   = 9'b001000000,
        M_BLOCK  = 9'b010000000,
        M_STAR   = 9'b100000000
    } mode_t;

    typedef enum logic [1:0] {
        RADIX_2  = 2'd0,
        RADIX_8  = 2'd1,
        RADIX_10 = 2'd2,
        RADIX_16 = 2'd3
    } radix_t;

    typedef struct packed {
        mode_t              mode;
        logic [7:0]         pend;
        radix_t             radix;
        logic [VALUE_W-1:0] acc;
        logic               ovf;
        logic               has_digit;
        logic [WIN_W-1:0]   window;
        logic [WLEN_W-1:0]  wlen;
        logic [POS_W-1:0]   line;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   tsc;
    } scan_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               err;
        logic               bval;
        logic [POS_W-1:0]   line;
        logic [POS_W-1:0]   sc;
        logic [POS_W-1:0]   ec;
        logic               last;
    } token_t;

    localparam logic [WIN_W-1:0] KW_LET      = "let";
    localparam logic [WIN_W-1:0] KW_FUNC     = "func";
    localparam logic [WIN_W-1:0] KW_RETURN   = "return";
    localparam logic [WIN_W-1:0] KW_PACKAGE  = "package";
    localparam logic [WIN_W-1:0] KW_STATIC   = "static";
    localparam logic [WIN_W-1:0] KW_IF       = "if";
    localparam logic [WIN_W-1:0] KW_ELSE     = "else";
    localparam logic [WIN_W-1:0] KW_WHILE    = "while";
    localparam logic [WIN_W-1:0] KW_DO       = "do";
    localparam logic [WIN_W-1:0] KW_SWITCH   = "switch";
    localparam logic [WIN_W-1:0] KW_FOR      = "for";
    localparam logic [WIN_W-1:0] KW_FOREACH  = "foreach";
    localparam logic [WIN_W-1:0] KW_BREAK    = "break";
    localparam logic [WIN_W-1:0] KW_BREAKALL = "breakall";
    localparam logic [WIN_W-1:0] KW_CONTINUE = "continue";
    localparam logic [WIN_W-1:0] KW_IN       = "in";
    localparam logic [WIN_W-1:0] KW_TRUE     = "true";
    localparam logic [WIN_W-1:0] KW_FALSE    = "false";

    function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
        case (c)
            "(":     punct_kind = 6'd1;
            ")":     punct_kind = 6'd2;
            "[":     punct_kind = 6'd3;
            "]":     punct_kind = 6'd4;
            "{":     punct_kind = 6'd5;
            "}":     punct_kind = 6'd6;
            ":":     punct_kind = 6'd7;
            ";":     punct_kind = 6'd8;
            ".":     punct_kind = 6'd9;
            ",":     punct_kind = 6'd10;
            "^":     punct_kind = 6'd11;
            default: punct_kind = 6'd0;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] oper_kind(input logic [7:0] c);
        case (c)
            "+":     oper_kind = 6'd12;
            "-":     oper_kind = 6'd13;
            "*":     oper_kind = 6'd14;
            "/":     oper_kind = 6'd15;
            "%":     oper_kind = 6'd16;
            "!":     oper_kind = 6'd17;
            ">":     oper_kind = 6'd18;
            "<":     oper_kind = 6'd19;
            "=":     oper_kind = 6'd20;
            "&":     oper_kind = 6'd21;
            "|":     oper_kind = 6'd22;
            default: oper_kind = 6'd0;
        endcase
    endfunction

    function automatic logic [4:0] digit_val(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd16;
            if (c inside {["0":"9"]}) t = c - "0";
            else if (c inside {["a":"f"]}) t = c - "a" + 8'd10;
            digit_val = t[4:0];
        end
    endfunction

    function automatic logic [4:0] radix_val(input radix_t r);
        case (r)
            RADIX_2:  radix_val = 5'd2;
            RADIX_8:  radix_val = 5'd8;
            RADIX_10: radix_val = 5'd10;
            RADIX_16: radix_val = 5'd16;
            default:  radix_val = 5'd10;
        endcase
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c inside {["a":"z"], ["A":"Z"], "_"});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c inside {["0":"9"]});
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        sat_inc = (v == POS_MAX) ? POS_MAX : v + 1'b1;
    endfunction

    // Words longer than the window never match; shorter ones are zero padded on the left.
    function automatic logic [KIND_W-1:0] kw_kind(input logic [WIN_W-1:0] w,
                                                  input logic [WLEN_W-1:0] len);
        logic [KIND_W-1:0] k;
        begin
            k = KIND_IDENT;
            if (len <= WLEN_W'(MAX_KW)) begin
                case (w)
                    KW_LET:      k = 6'd37;
                    KW_FUNC:     k = 6'd38;
                    KW_RETURN:   k = 6'd39;
                    KW_PACKAGE:  k = 6'd40;
                    KW_STATIC:   k = 6'd41;
                    KW_IF:       k = 6'd42;
                    KW_ELSE:     k = 6'd43;
                    KW_WHILE:    k = 6'd44;
                    KW_DO:       k = 6'd45;
                    KW_SWITCH:   k = 6'd46;
                    KW_FOR:      k = 6'd47;
                    KW_FOREACH:  k = 6'd48;
                    KW_BREAK:    k = 6'd49;
                    KW_BREAKALL: k = 6'd50;
                    KW_CONTINUE: k = 6'd51;
                    KW_IN:       k = 6'd52;
                    KW_TRUE:     k = KIND_BOOL;
                    KW_FALSE:    k = KIND_BOOL;
                    default:     k = KIND_IDENT;
                endcase
            end
            kw_kind = k;
        end
    endfunction

endpackage
`default_nettype wire

/* design/stc_step.sv */
// Combinational scanner step: next state and up to two tokens for one input word.
`default_nettype none
module stc_step
    import stc_pkg::*;
(
    input  scan_state_t st,
    input  logic [7:0]  char_byte,
    input  logic        end_of_input,
    output scan_state_t nx,
    output logic        a_valid,
    output token_t      a_tok,
    output logic        b_valid,
    output token_t      b_tok
);

    logic [POS_W-1:0]   col;
    logic [4:0]         dval;
    logic               dig_ok;
    logic               run_idle;
    logic               num_path;
    logic               num_err;
    logic [KIND_W-1:0]  pk;
    logic [KIND_W-1:0]  wk;
    logic [VALUE_W+4:0] scaled;
    logic [VALUE_W+4:0] prod;
    logic [VALUE_W+4:0] acc_w;

    always_comb
    begin
        col     = sat_inc(st.col);
        dval    = digit_val(char_byte);
        dig_ok  = dval < radix_val(st.radix);
        num_err = st.ovf || (st.mode == M_PREFIX && !st.has_digit);
        pk      = oper_kind(st.pend);
        wk      = kw_kind(st.window, st.wlen);
        acc_w   = {5'd0, st.acc};
        case (st.radix)
            RADIX_2:  scaled = acc_w << 1;
            RADIX_8:  scaled = acc_w << 3;
            RADIX_16: scaled = acc_w << 4;
            default:  scaled = (acc_w << 3) + (acc_w << 1);
        endcase
        prod = scaled + {{(VALUE_W){1'b0}}, dval};

        nx       = st;
        run_idle = 1'b0;
        num_path = 1'b0;
        a_valid  = 1'b0;
        b_valid  = 1'b0;
        a_tok    = '0;
        b_tok    = '0;
        a_tok.line = st.line;
        b_tok.line = st.line;
        b_tok.last = 1'b1;

        if (end_of_input)
        begin
            case (st.mode)
                M_OPER:
                begin
                    a_valid   = 1'b1;
                    a_tok.kind = pk;
                    a_tok.sc  = st.tsc;
                    a_tok.ec  = st.tsc;
                end
                M_ZERO, M_DEC, M_PREFIX:
                begin
                    a_valid     = 1'b1;
                    a_tok.kind  = KIND_NUMBER;
                    a_tok.value = num_err ? '0 : st.acc;
                    a_tok.err   = num_err;
                    a_tok.sc    = st.tsc;
                    a_tok.ec    = st.col;
                end
                M_WORD:
                begin
                    a_valid    = 1'b1;
                    a_tok.kind = wk;
                    a_tok.bval = (st.window == KW_TRUE);
                    a_tok.sc   = st.tsc;
                    a_tok.ec   = st.col;
                end
                default:
                begin
                end
            endcase
            nx.mode    = M_IDLE;
            nx.pend    = '0;
            nx.line    = sat_inc(st.line);
            b_valid    = 1'b1;
            b_tok.kind = KIND_EOF;
            b_tok.line = nx.line;
        end
        else
        begin
            nx.col = col;
            case (st.mode)
                M_OPER:
                begin
                    if (st.pend == CH_SLASH && char_byte == CH_SLASH)
                        nx.mode = M_LINE;
                    else if (st.pend == CH_SLASH && char_byte == CH_STAR)
                        nx.mode = M_BLOCK;
                    else if ((char_byte == CH_EQ && st.pend != CH_AMP && st.pend != CH_BAR)
                             || ((st.pend == CH_AMP || st.pend == CH_BAR)
                                 && char_byte == st.pend))
                    begin
                        a_valid    = 1'b1;
                        a_tok.kind = pk + KIND_ASSIGN;
                        a_tok.sc   = st.tsc;
                        a_tok.ec   = col;
                        nx.mode    = M_IDLE;
                        nx.pend    = '0;
                    end
                    else
                    begin
                        a_valid    = 1'b1;
                        a_tok.kind = pk;
                        a_tok.sc   = st.tsc;
                        a_tok.ec   = st.tsc;
                        run_idle   = 1'b1;
                    end
                end
                M_ZERO:
                begin
                    if (char_byte inside {"b", "o", "d", "x"})
                    begin
                        case (char_byte)
                            "b":     nx.radix = RADIX_2;
                            "o":     nx.radix = RADIX_8;
                            "d":     nx.radix = RADIX_10;
                            default: nx.radix = RADIX_16;
                        endcase
                        nx.acc       = '0;
                        nx.has_digit = 1'b0;
                        nx.mode      = M_PREFIX;
                    end
                    else
                    begin
                        nx.mode  = M_DEC;
                        num_path = 1'b1;
                    end
                end
                M_DEC, M_PREFIX:
                    num_path = 1'b1;
                M_WORD:
                begin
                    if (is_letter(char_byte) || is_digit(char_byte))
                    begin
                        nx.window = {st.window[WIN_W-9:0], char_byte};
                        if (st.wlen <= WLEN_W'(MAX_KW))
                            nx.wlen = st.wlen + 1'b1;
                    end
                    else
                    begin
                        a_valid    = 1'b1;
                        a_tok.kind = wk;
                        a_tok.bval = (st.window == KW_TRUE);
                        a_tok.sc   = st.tsc;
                        a_tok.ec   = st.col;
                        run_idle   = 1'b1;
                    end
                end
                M_LINE:
                begin
                    if (char_byte == CH_NL)
                    begin
                        nx.line = sat_inc(st.line);
                        nx.col  = '0;
                        nx.mode = M_IDLE;
                    end
                end
                M_BLOCK, M_STAR:
                begin
                    if (char_byte == CH_NL)
                    begin
                        nx.line = sat_inc(st.line);
                        nx.col  = '0;
                        nx.mode = M_BLOCK;
                    end
                    else if (char_byte == CH_SLASH && st.mode == M_STAR)
                        nx.mode = M_IDLE;
                    else
                        nx.mode = (char_byte == CH_STAR) ? M_STAR : M_BLOCK;
                end
                default:
                    run_idle = 1'b1;
            endcase

            if (num_path)
            begin
                if (dig_ok)
                begin
                    nx.has_digit = 1'b1;
                    if (!st.ovf)
                    begin
                        if (prod > {5'd0, NUM_MAX})
                            nx.ovf = 1'b1;
                        else
                            nx.acc = prod[VALUE_W-1:0];
                    end
                end
                else
                begin
                    a_valid     = 1'b1;
                    a_tok.kind  = KIND_NUMBER;
                    a_tok.value = num_err ? '0 : st.acc;
                    a_tok.err   = num_err;
                    a_tok.sc    = st.tsc;
                    a_tok.ec    = st.col;
                    run_idle    = 1'b1;
                end
            end

            if (run_idle)
            begin
                nx.mode = M_IDLE;
                nx.pend = '0;
                if (char_byte == CH_NL)
                begin
                    nx.line = sat_inc(st.line);
                    nx.col  = '0;
                end
                else if (punct_kind(char_byte) != '0)
                begin
                    b_valid    = 1'b1;
                    b_tok.kind = punct_kind(char_byte);
                    b_tok.sc   = col;
                    b_tok.ec   = col;
                end
                else
                begin
                    nx.tsc = col;
                    if (oper_kind(char_byte) != '0)
                    begin
                        nx.pend = char_byte;
                        nx.mode = M_OPER;
                    end
                    else if (is_digit(char_byte))
                    begin
                        nx.radix     = RADIX_10;
                        nx.ovf       = 1'b0;
                        nx.has_digit = 1'b0;
                        nx.acc       = VALUE_W'(char_byte - CH_ZERO);
                        nx.mode      = (char_byte == CH_ZERO) ? M_ZERO : M_DEC;
                    end
                    else if (is_letter(char_byte))
                    begin
                        nx.window = WIN_W'(char_byte);
                        nx.wlen   = WLEN_W'(1);
                        nx.mode   = M_WORD;
                    end
                end
            end
        end
        a_tok.last = !b_valid;
    end

endmodule
`default_nettype wire

/* design/stc_outq.sv */
// Four-entry token queue with two write slots per cycle and one read port.
`default_nettype none
module stc_outq
    import stc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  logic   a_valid,
    input  token_t a_tok,
    input  logic   b_valid,
    input  token_t b_tok,
    output logic   room,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t head
);

    token_t     entry_reg [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] n_push;

    assign room      = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign head      = entry_reg[rp_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = push ? ({1'b0, a_valid} + {1'b0, b_valid}) : 2'd0;

    always_comb
    begin
        wp_next  = wp_reg + n_push;
        rp_next  = rp_reg + {1'b0, pop};
        cnt_next = cnt_reg + {1'b0, n_push} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (a_valid)
            begin
                entry_reg[wp_reg] <= a_tok;
                if (b_valid)
                    entry_reg[wp_reg + 2'd1] <= b_tok;
            end
            else if (b_valid)
                entry_reg[wp_reg] <= b_tok;
        end
    end

endmodule
`default_nettype wire

/* design/source_code_tokenizer_core.sv */
// Top level of the streaming source tokenizer: scanner state, step logic and token queue.
//
// Usage: source bytes enter on the in channel (char_byte, end_of_input) under
// in_valid/in_ready, one word per cycle while in_ready is high. Each accepted
// word is scanned in the same cycle against the scanner state registers and
// produces zero, one or two tokens, which are written into a four-entry token
// queue. Tokens leave on the out channel under out_valid/out_ready, one per
// cycle, with last_of_run set on the final token caused by an input word. A
// token is held in a queue register until the tokens ahead of it have left.
// Throughput is one input word per cycle as long as the receiver keeps up; a
// word that yields two tokens occupies the output for both tokens, and in_ready
// drops whenever the queue has fewer than two free entries. A stalled receiver
// therefore fills the queue and then holds off the sender without loss.
// The cfg channel (cfg_valid/cfg_ready, cfg_data) loads the line counter with
// the first line number; it is always ready; the user must write it only while
// the block is idle (not enforced). Reset clears the scanner to idle, the line
// counter to one, the column to zero and empties the queue.
`default_nettype none
module source_code_tokenizer_core
    import stc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [POS_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          char_byte,
    input  logic                end_of_input,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   token_kind,
    output logic [VALUE_W-1:0]  number_value,
    output logic                number_error,
    output logic                bool_value,
    output logic [POS_W-1:0]    line_number,
    output logic [POS_W-1:0]    start_column,
    output logic [POS_W-1:0]    end_column,
    output logic                last_of_run
);

    scan_state_t st_reg, st_next, step_nx;
    logic        a_valid, b_valid;
    token_t      a_tok, b_tok, head;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    stc_step u_step (
        .st           (st_reg),
        .char_byte    (char_byte),
        .end_of_input (end_of_input),
        .nx           (step_nx),
        .a_valid      (a_valid),
        .a_tok        (a_tok),
        .b_valid      (b_valid),
        .b_tok        (b_tok)
    );

    // The user must write config only while idle (unenforced); it overrides the line.
    always_comb
    begin
        st_next = accept ? step_nx : st_reg;
        if (cfg_valid)
            st_next.line = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode      <= M_IDLE;
            st_reg.pend      <= '0;
            st_reg.radix     <= RADIX_10;
            st_reg.acc       <= '0;
            st_reg.ovf       <= 1'b0;
            st_reg.has_digit <= 1'b0;
            st_reg.window    <= '0;
            st_reg.wlen      <= '0;
            st_reg.line      <= POS_W'(1);
            st_reg.col       <= '0;
            st_reg.tsc       <= '0;
        end
        else
            st_reg <= st_next;
    end

    stc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .a_valid   (a_valid),
        .a_tok     (a_tok),
        .b_valid   (b_valid),
        .b_tok     (b_tok),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign token_kind   = head.kind;
    assign number_value = head.value;
    assign number_error = head.err;
    assign bool_value   = head.bval;
    assign line_number  = head.line;
    assign start_column = head.sc;
    assign end_column   = head.ec;
    assign last_of_run  = head.last;

endmodule
`default_nettype wire

/* design/stc_checker.sv */
// Port-level checker for the tokenizer and the bind that attaches it.
`default_nettype none
module stc_checker
    import stc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [KIND_W-1:0]  token_kind,
    input  logic [VALUE_W-1:0] number_value,
    input  logic               number_error,
    input  logic               bool_value,
    input  logic [POS_W-1:0]   start_column,
    input  logic [POS_W-1:0]   end_column,
    input  logic               last_of_run
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("token dropped while stalled");

    a_eof: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_EOF |->
            start_column == '0 && end_column == '0 && last_of_run)
        else $error("bad end of file token");

    a_numfields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != KIND_NUMBER |-> number_value == '0 && !number_error)
        else $error("number fields on a non-number token");

    a_bool: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bool_value |-> token_kind == KIND_BOOL)
        else $error("bool value on a non-boolean token");

    a_cols: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> start_column <= end_column)
        else $error("token ends before it starts");

endmodule

bind source_code_tokenizer_core stc_checker u_stc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .number_value (number_value),
    .number_error (number_error),
    .bool_value   (bool_value),
    .start_column (start_column),
    .end_column   (end_column),
    .last_of_run  (last_of_run)
);
`default_nettype wire
